// File: sv/rnf_pkg.sv
package rnf_pkg;

   // unit length counters are cut to this many bits
   localparam int LEN_BITS = 20;
   localparam int MAXP_W   = 12;
   localparam int PLEN_W   = 13;
   localparam int SEQ_W    = 16;
   localparam int SUM_W    = ((LEN_BITS > MAXP_W) ? LEN_BITS : MAXP_W) + 1;

   // apb register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RESET = MAXP_W'(1400);
   localparam logic [SEQ_W-1:0]  INITIAL_SEQ_RESET = '0;

   typedef enum logic {
      REG_MAX_PAYLOAD = 1'b0,
      REG_INITIAL_SEQ = 1'b1
   } reg_index_type;

   // fu-a header fields
   localparam logic [7:0] FU_NRI_MASK = 8'hE0;
   localparam logic [7:0] FU_A_TYPE   = 8'd28;
   localparam logic [7:0] TYPE_MASK   = 8'h1F;
   localparam logic [7:0] FU_S_BIT    = 8'h80;
   localparam logic [7:0] FU_E_BIT    = 8'h40;

   // up to three output words per input word
   localparam int MAX_RUN = 3;
   typedef logic [1:0] run_count_type;
   typedef logic [1:0] run_index_type;

   typedef struct packed {
      logic [7:0]  nalu_byte;
      logic        nalu_first;
      logic [19:0] nalu_len;
      logic [31:0] rtp_time;
   } req_word_type;

   typedef struct packed {
      logic [7:0]        payload_byte;
      logic              packet_start;
      logic              packet_end;
      logic              marker_bit;
      logic [SEQ_W-1:0]  seq_num;
      logic [31:0]       packet_time;
      logic [PLEN_W-1:0] payload_length;
      logic              run_last;
   } rsp_word_type;

   typedef struct packed {
      rsp_word_type [MAX_RUN-1:0] words;
      run_count_type              count;
   } run_type;

   typedef struct packed {
      logic [MAXP_W-1:0] max_payload;
      logic              seq_load;
      logic [SEQ_W-1:0]  seq_value;
   } csr_ctrl_type;

endpackage

// File: sv/rtp_nalu_fragmenter_core.sv
// an accepted word is held in the input register, then loaded into the rsp buffer
// throughput: one input word per cycle while rsp_ready is high and each yields
// one output word; a byte that opens a fragment yields three words and holds the
// input until its last word leaves through the single rsp register stage
// reset: synchronous, active high; empties the pipeline, clears the unit counters
// and flags, max_payload returns to 1400 and the sequence counter to 0
module rtp_nalu_fragmenter_core import rnf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   csr_ctrl_type ctrl;
   run_type      run;
   logic         run_load;
   logic         take;

   // configuration registers
   rnf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .ctrl    (ctrl)
   );

   // input register and packetizing logic
   rnf_frag u_frag (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .take      (take),
      .run_load  (run_load),
      .run       (run)
   );

   // output word buffer
   rnf_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .run_load  (run_load),
      .run       (run),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/rnf_csr.sv
module rnf_csr import rnf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output csr_ctrl_type          ctrl
);

   logic [MAXP_W-1:0] max_payload_ff, max_payload_in;
   logic [SEQ_W-1:0]  initial_seq_ff, initial_seq_in;
   reg_index_type     reg_sel;
   logic              wr_en;

   assign reg_sel = reg_index_type'(paddr[CSR_ADDR_W-1]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   // register write decode
   always_comb begin
      max_payload_in = max_payload_ff;
      initial_seq_in = initial_seq_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MAX_PAYLOAD: max_payload_in = pwdata[MAXP_W-1:0];
            REG_INITIAL_SEQ: initial_seq_in = pwdata[SEQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
         initial_seq_ff <= INITIAL_SEQ_RESET;
      end else begin
         max_payload_ff <= max_payload_in;
         initial_seq_ff <= initial_seq_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_MAX_PAYLOAD: prdata = CSR_DATA_W'(max_payload_ff);
         REG_INITIAL_SEQ: prdata = CSR_DATA_W'(initial_seq_ff);
         default:         prdata = '0;
      endcase
   end

   // sequence counter load rides on the write strobe
   assign ctrl.max_payload = max_payload_ff;
   assign ctrl.seq_load    = wr_en && (reg_sel == REG_INITIAL_SEQ);
   assign ctrl.seq_value   = pwdata[SEQ_W-1:0];

endmodule

// File: sv/rnf_frag.sv
module rnf_frag import rnf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   input  csr_ctrl_type ctrl,
   input  logic         take,
   output logic         run_load,
   output run_type      run
);

   // input register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         advance;

   // unit state
   logic [7:0]          hdr_ff, hdr_in;
   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic                head_ff, head_in;
   logic                frag_ff, frag_in;
   logic [MAXP_W-1:0]   fill_ff, fill_in;
   logic                sbit_ff, sbit_in;
   logic [PLEN_W-1:0]   ulen_ff, ulen_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [31:0]         time_ff, time_in;

   // working values
   logic [MAXP_W-1:0]   max_pl;
   logic [LEN_BITS-1:0] len_cut, len_eff;
   logic [7:0]          cur_hdr;
   logic [LEN_BITS-1:0] cur_rem;
   logic                cur_head, cur_frag, cur_sbit;
   logic [MAXP_W-1:0]   cur_fill;
   logic [PLEN_W-1:0]   cur_ulen;
   logic [31:0]         cur_time;
   logic                rem_zero, rem_one;
   logic [SUM_W-1:0]    frag_left, plen_sel;
   logic                is_last, fill_full, frag_end;
   logic [PLEN_W-1:0]   frag_plen;
   logic [PLEN_W-1:0]   fill_inc;
   logic [7:0]          fu_hdr;
   logic                single_word, frag_data;
   rsp_word_type        base_word;

   assign advance   = in_valid_ff && take;
   assign req_ready = !in_valid_ff || take;
   assign run_load  = advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
   end

   // effective limits; a first byte reloads the unit state
   assign max_pl  = (ctrl.max_payload == '0) ? MAXP_W'(1) : ctrl.max_payload;
   assign len_cut = LEN_BITS'(in_word_ff.nalu_len);
   assign len_eff = (len_cut == '0) ? LEN_BITS'(1) : len_cut;

   always_comb begin
      if (in_word_ff.nalu_first) begin
         cur_hdr  = in_word_ff.nalu_byte;
         cur_rem  = len_eff;
         cur_head = 1'b1;
         cur_frag = SUM_W'(len_eff) > SUM_W'(max_pl);
         cur_fill = '0;
         cur_sbit = 1'b1;
         cur_ulen = PLEN_W'(len_eff);
         cur_time = in_word_ff.rtp_time;
      end else begin
         cur_hdr  = hdr_ff;
         cur_rem  = rem_ff;
         cur_head = head_ff;
         cur_frag = frag_ff;
         cur_fill = fill_ff;
         cur_sbit = sbit_ff;
         cur_ulen = ulen_ff;
         cur_time = time_ff;
      end
   end

   // fragment bookkeeping
   assign rem_zero  = (cur_rem == '0);
   assign rem_one   = (cur_rem == LEN_BITS'(1));
   assign frag_left = SUM_W'(cur_rem) + SUM_W'(cur_fill);
   assign is_last   = frag_left <= SUM_W'(max_pl);
   assign plen_sel  = is_last ? frag_left : SUM_W'(max_pl);
   assign frag_plen = PLEN_W'(plen_sel + SUM_W'(2));
   assign fill_inc  = PLEN_W'(cur_fill) + PLEN_W'(1);
   assign fill_full = fill_inc >= PLEN_W'(max_pl);
   assign frag_end  = rem_one || fill_full;

   assign single_word = !rem_zero && !cur_frag;
   assign frag_data   = !rem_zero && cur_frag && !cur_head;

   always_comb begin
      fu_hdr = cur_hdr & TYPE_MASK;
      if (cur_sbit)
         fu_hdr = fu_hdr | FU_S_BIT;
      if (is_last)
         fu_hdr = fu_hdr | FU_E_BIT;
   end

   // build the run of output words
   always_comb begin
      base_word.payload_byte   = in_word_ff.nalu_byte;
      base_word.packet_start   = 1'b0;
      base_word.packet_end     = frag_end;
      base_word.marker_bit     = is_last;
      base_word.seq_num        = seq_ff;
      base_word.packet_time    = cur_time;
      base_word.payload_length = frag_plen;
      base_word.run_last       = 1'b1;

      run.words = {MAX_RUN{base_word}};
      run.count = run_count_type'(0);
      if (single_word) begin
         run.count                     = run_count_type'(1);
         run.words[0].packet_start     = cur_head;
         run.words[0].packet_end       = rem_one;
         run.words[0].marker_bit       = 1'b1;
         run.words[0].payload_length   = cur_ulen;
      end else if (frag_data) begin
         if (cur_fill == '0) begin
            run.count                  = run_count_type'(MAX_RUN);
            run.words[0].payload_byte  = (cur_hdr & FU_NRI_MASK) | FU_A_TYPE;
            run.words[0].packet_start  = 1'b1;
            run.words[0].packet_end    = 1'b0;
            run.words[0].run_last      = 1'b0;
            run.words[1].payload_byte  = fu_hdr;
            run.words[1].packet_end    = 1'b0;
            run.words[1].run_last      = 1'b0;
         end else begin
            run.count = run_count_type'(1);
         end
      end
   end

   // next unit state
   always_comb begin
      hdr_in  = cur_hdr;
      rem_in  = rem_zero ? cur_rem : cur_rem - LEN_BITS'(1);
      head_in = rem_zero ? cur_head : 1'b0;
      frag_in = cur_frag;
      fill_in = cur_fill;
      sbit_in = cur_sbit;
      ulen_in = cur_ulen;
      time_in = cur_time;
      seq_in  = seq_ff;
      if (frag_data) begin
         fill_in = frag_end ? '0 : MAXP_W'(fill_inc);
         sbit_in = 1'b0;
      end
      if ((single_word && rem_one) || (frag_data && frag_end))
         seq_in = seq_ff + SEQ_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         head_ff <= 1'b0;
         frag_ff <= 1'b0;
         fill_ff <= '0;
         sbit_ff <= 1'b0;
         seq_ff  <= INITIAL_SEQ_RESET;
      end else if (ctrl.seq_load) begin
         seq_ff <= ctrl.seq_value;
      end else if (advance) begin
         rem_ff  <= rem_in;
         head_ff <= head_in;
         frag_ff <= frag_in;
         fill_ff <= fill_in;
         sbit_ff <= sbit_in;
         seq_ff  <= seq_in;
      end
      if (advance) begin
         hdr_ff  <= hdr_in;
         ulen_ff <= ulen_in;
         time_ff <= time_in;
      end
   end

endmodule

// File: sv/rnf_emit.sv
module rnf_emit import rnf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         run_load,
   input  run_type      run,
   output logic         take,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   rsp_word_type  words_ff [MAX_RUN];
   run_count_type count_ff, count_in;
   run_index_type pos_ff, pos_in;
   logic          pop;

   assign rsp_valid = (count_ff != run_count_type'(0));
   assign rsp_data  = words_ff[pos_ff];
   assign pop       = rsp_valid && rsp_ready;
   // room for a new run once the last buffered word leaves
   assign take      = (count_ff == run_count_type'(0)) ||
                      ((count_ff == run_count_type'(1)) && rsp_ready);

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      if (run_load) begin
         count_in = run.count;
         pos_in   = '0;
      end else if (pop) begin
         count_in = count_ff - run_count_type'(1);
         pos_in   = pos_ff + run_index_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
      if (run_load) begin
         for (int i = 0; i < MAX_RUN; i++) begin
            words_ff[i] <= run.words[i];
         end
      end
   end

endmodule

// File: sv/rnf_checker.sv
module rnf_checker import rnf_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data
);

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a packet only ends on the last word of an input byte
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.packet_end) |-> rsp_data.run_last)
      else $error("packet_end on a word that is not the last of its run");

   // a packet start that is not alone is an fu-a indicator
   a_fu_indicator: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.packet_start && !rsp_data.run_last) |->
      ((rsp_data.payload_byte & TYPE_MASK) == FU_A_TYPE))
      else $error("fragment start word is not an fu-a indicator");

   // the rest of a run follows at once within the same packet
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.run_last) |=>
      (rsp_valid && (rsp_data.seq_num == $past(rsp_data.seq_num))))
      else $error("run broken or sequence number changed inside a run");

   // stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("output word changed while stalled");

endmodule

bind rtp_nalu_fragmenter_core rnf_checker u_checker (.*);
